### design/lpd_pkg.sv
// lpd_pkg: shared constants, types and codes for the laplace pseudo-density block
// no dependencies; imported by lpd_mac and laplace_pseudo_density
package lpd_pkg;

	localparam int MAX_BASIS   = 64;
	localparam int MAX_WEIGHTS = 16;
	localparam int BASIS_W     = $clog2(MAX_BASIS);
	localparam int WEIGHT_W    = $clog2(MAX_WEIGHTS);
	localparam int COUNT_W     = BASIS_W + 1;
	localparam int COEF_DEPTH  = MAX_BASIS * MAX_BASIS;
	localparam int WT_DEPTH    = MAX_WEIGHTS * MAX_BASIS;

	localparam int VALUE_W     = 32;
	localparam int DENS_W      = 48;
	localparam int FRAC_BITS   = 27;
	localparam int PROD_W      = 2 * VALUE_W;
	localparam int HI_W        = PROD_W - 2 * FRAC_BITS;
	localparam int LOT_W       = PROD_W - FRAC_BITS;
	localparam int TERM_W      = 43;
	localparam int SUM_W       = DENS_W + 2;

	localparam int NB_W        = 7;
	localparam int NW_W        = 5;
	localparam logic [NB_W-1:0] NUM_BASIS_RST    = 7'd64;
	localparam logic [NB_W-1:0] NUM_OCCUPIED_RST = 7'd32;
	localparam logic [NB_W-1:0] NUM_VIRTUAL_RST  = 7'd32;
	localparam logic [NW_W-1:0] NUM_WEIGHTS_RST  = 5'd8;

	typedef enum logic [1:0] {
		REQ_COEF  = 2'd0,
		REQ_OCC   = 2'd1,
		REQ_VIR   = 2'd2,
		REQ_QUERY = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		REG_NUM_BASIS    = 2'd0,
		REG_NUM_OCCUPIED = 2'd1,
		REG_NUM_VIRTUAL  = 2'd2,
		REG_NUM_WEIGHTS  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MUL_AB,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SEL_AB,
		SEL_LO,
		SEL_HI
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     mul_en;
		logic     acc_clear;
		logic     acc_en;
		logic     acc_vir;
	} mac_ctrl_t;

endpackage

### design/lpd_ram.sv
// lpd_ram: generic single-write, single-read ram with registered read data
// no dependencies; used for the coefficient and weight stores
module lpd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/lpd_mac.sv
// lpd_mac: shared 32x32 multiplier with term assembly and two saturating accumulators
// depends on lpd_pkg
module lpd_mac
	import lpd_pkg::*;
(
	input  logic                      clk,
	input  mac_ctrl_t                 ctrl,
	input  logic signed [VALUE_W-1:0] coef_a,
	input  logic signed [VALUE_W-1:0] coef_b,
	input  logic signed [VALUE_W-1:0] weight,
	output logic signed [DENS_W-1:0]  occ_density,
	output logic signed [DENS_W-1:0]  vir_density
);

	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(DENS_W-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

	logic signed [PROD_W-1:0]  mul_q;
	logic signed [HI_W-1:0]    hi_q;
	logic signed [LOT_W-1:0]   lot_q;
	logic signed [DENS_W-1:0]  occ_q;
	logic signed [DENS_W-1:0]  vir_q;

	logic signed [VALUE_W-1:0] op_x;
	logic signed [VALUE_W-1:0] op_y;
	logic signed [PROD_W-1:0]  product;
	logic signed [TERM_W-1:0]  term;
	logic signed [SUM_W-1:0]   sum;
	logic signed [DENS_W-1:0]  sat;

	// operand select: a*b, then low part of p times l, then high part of p times l
	always_comb begin
		unique case (ctrl.mul_sel)
			SEL_AB: begin
				op_x = coef_a;
				op_y = coef_b;
			end
			SEL_LO: begin
				op_x = $signed(VALUE_W'(mul_q[2*FRAC_BITS-1:FRAC_BITS]));
				op_y = weight;
			end
			SEL_HI: begin
				op_x = VALUE_W'(hi_q);
				op_y = weight;
			end
			default: begin
				op_x = '0;
				op_y = '0;
			end
		endcase
	end

	assign product = op_x * op_y;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			mul_q <= product;
			if (ctrl.mul_sel == SEL_LO) begin
				hi_q <= mul_q[PROD_W-1:2*FRAC_BITS];
			end
			if (ctrl.mul_sel == SEL_HI) begin
				lot_q <= mul_q[PROD_W-1:FRAC_BITS];
			end
		end
	end

	assign term = $signed(mul_q[TERM_W-1:0]) + TERM_W'(lot_q);

	always_comb begin
		sum = (ctrl.acc_vir ? SUM_W'(vir_q) : SUM_W'(occ_q)) + SUM_W'(term);
		if (sum > SAT_MAX) begin
			sat = DENS_W'(SAT_MAX);
		end else if (sum < SAT_MIN) begin
			sat = DENS_W'(SAT_MIN);
		end else begin
			sat = sum[DENS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.acc_clear) begin
			occ_q <= '0;
			vir_q <= '0;
		end else if (ctrl.acc_en) begin
			if (ctrl.acc_vir) begin
				vir_q <= sat;
			end else begin
				occ_q <= sat;
			end
		end
	end

	assign occ_density = occ_q;
	assign vir_density = vir_q;

endmodule

### design/laplace_pseudo_density.sv
// laplace_pseudo_density: top level with apb registers, stores, query sequencer
// depends on lpd_pkg, lpd_ram and lpd_mac
//
// Coefficient and weight loads are taken while idle. A query walks the orbitals
// 0..nend-1 (nend = occupied plus virtual count, clipped to num_basis) through one
// shared 32x32 multiplier that is used three times per orbital: after a fetch state, each orbital
// runs mul_ab, mul_lo, mul_hi and acc, then done. Out-of-range queries go straight to done.
// The input channel stalls for the whole query and until the result register is free;
// loads are taken while a result still waits. The coefficient store is held twice so
// both coefficients of an orbital read in the same cycle. Stores have no reset.
module laplace_pseudo_density
	import lpd_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 req_type,
	input  logic [3:0]                 weight_index,
	input  logic [5:0]                 row,
	input  logic [5:0]                 column,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [3:0]                 out_weight_index,
	output logic [5:0]                 out_row,
	output logic [5:0]                 out_column,
	output logic signed [DENS_W-1:0]   occ_density,
	output logic signed [DENS_W-1:0]   vir_density
);

	logic [NB_W-1:0] num_basis_q;
	logic [NB_W-1:0] num_occupied_q;
	logic [NB_W-1:0] num_virtual_q;
	logic [NW_W-1:0] num_weights_q;

	state_t            state_q, state_d;
	logic [3:0]        w_q;
	logic [5:0]        row_q;
	logic [5:0]        col_q;
	logic [COUNT_W-1:0] k_q;
	logic [COUNT_W-1:0] nocc_q;
	logic [COUNT_W-1:0] nend_q;
	logic              more_q;
	logic              acc_vir_q;

	logic                      out_valid_q;
	logic [3:0]                out_weight_index_q;
	logic [5:0]                out_row_q;
	logic [5:0]                out_column_q;
	logic signed [DENS_W-1:0]  occ_out_q;
	logic signed [DENS_W-1:0]  vir_out_q;

	logic              cfg_wr;
	logic              in_acc;
	logic              query_acc;
	logic              out_free;
	logic [NB_W-1:0]   nb;
	logic [NW_W-1:0]   nw;
	logic [NB_W-1:0]   nocc;
	logic [NB_W:0]     nsum;
	logic [NB_W-1:0]   nend;
	logic              in_range;
	logic              in_vir;
	logic [BASIS_W-1:0] wcol;
	logic [BASIS_W-1:0] kcol;

	mac_ctrl_t                 ctrl;
	logic signed [VALUE_W-1:0] coef_a;
	logic signed [VALUE_W-1:0] coef_b;
	logic [VALUE_W-1:0]        coef_a_raw;
	logic [VALUE_W-1:0]        coef_b_raw;
	logic [VALUE_W-1:0]        occ_w_raw;
	logic [VALUE_W-1:0]        vir_w_raw;
	logic signed [DENS_W-1:0]  occ_acc;
	logic signed [DENS_W-1:0]  vir_acc;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_basis_q    <= NUM_BASIS_RST;
			num_occupied_q <= NUM_OCCUPIED_RST;
			num_virtual_q  <= NUM_VIRTUAL_RST;
			num_weights_q  <= NUM_WEIGHTS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_NUM_BASIS:    num_basis_q    <= pwdata[NB_W-1:0];
				REG_NUM_OCCUPIED: num_occupied_q <= pwdata[NB_W-1:0];
				REG_NUM_VIRTUAL:  num_virtual_q  <= pwdata[NB_W-1:0];
				REG_NUM_WEIGHTS:  num_weights_q  <= pwdata[NW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_NUM_BASIS:    prdata = 32'(num_basis_q);
			REG_NUM_OCCUPIED: prdata = 32'(num_occupied_q);
			REG_NUM_VIRTUAL:  prdata = 32'(num_virtual_q);
			REG_NUM_WEIGHTS:  prdata = 32'(num_weights_q);
			default:          prdata = '0;
		endcase
	end

	// item acceptance and query bounds
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign query_acc = in_acc && (req_t'(req_type) == REQ_QUERY);

	always_comb begin
		nb   = (num_basis_q < NB_W'(MAX_BASIS)) ? num_basis_q : NB_W'(MAX_BASIS);
		nw   = (num_weights_q < NW_W'(MAX_WEIGHTS)) ? num_weights_q : NW_W'(MAX_WEIGHTS);
		nocc = (num_occupied_q < nb) ? num_occupied_q : nb;
		nsum = {1'b0, nocc} + {1'b0, num_virtual_q};
		nend = (nsum < {1'b0, nb}) ? nsum[NB_W-1:0] : nb;
		in_range = ({1'b0, weight_index} < nw) && ({1'b0, row} < nb)
			&& ({1'b0, column} < nb);
	end

	// stores
	assign in_vir = (k_q >= nocc_q);
	assign kcol   = k_q[BASIS_W-1:0];
	assign wcol   = in_vir ? (kcol - nocc_q[BASIS_W-1:0]) : kcol;

	lpd_ram #(.WIDTH(VALUE_W), .DEPTH(COEF_DEPTH)) u_coef_a (
		.clk   (clk),
		.we    (in_acc && (req_t'(req_type) == REQ_COEF)),
		.waddr ({row, column}),
		.wdata (value),
		.raddr ({row_q, kcol}),
		.rdata (coef_a_raw)
	);

	lpd_ram #(.WIDTH(VALUE_W), .DEPTH(COEF_DEPTH)) u_coef_b (
		.clk   (clk),
		.we    (in_acc && (req_t'(req_type) == REQ_COEF)),
		.waddr ({row, column}),
		.wdata (value),
		.raddr ({col_q, kcol}),
		.rdata (coef_b_raw)
	);

	lpd_ram #(.WIDTH(VALUE_W), .DEPTH(WT_DEPTH)) u_occ_wt (
		.clk   (clk),
		.we    (in_acc && (req_t'(req_type) == REQ_OCC)),
		.waddr ({weight_index, column}),
		.wdata (value),
		.raddr ({w_q, wcol}),
		.rdata (occ_w_raw)
	);

	lpd_ram #(.WIDTH(VALUE_W), .DEPTH(WT_DEPTH)) u_vir_wt (
		.clk   (clk),
		.we    (in_acc && (req_t'(req_type) == REQ_VIR)),
		.waddr ({weight_index, column}),
		.wdata (value),
		.raddr ({w_q, wcol}),
		.rdata (vir_w_raw)
	);

	assign coef_a = $signed(coef_a_raw);
	assign coef_b = $signed(coef_b_raw);

	lpd_mac u_mac (
		.clk         (clk),
		.ctrl        (ctrl),
		.coef_a      (coef_a),
		.coef_b      (coef_b),
		.weight      (acc_vir_q ? $signed(vir_w_raw) : $signed(occ_w_raw)),
		.occ_density (occ_acc),
		.vir_density (vir_acc)
	);

	// sequencer
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		ctrl           = '0;
		ctrl.mul_sel   = SEL_AB;
		ctrl.acc_vir   = acc_vir_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query_acc) begin
					ctrl.acc_clear = 1'b1;
					state_d = (in_range && (nend != '0)) ? ST_FETCH : ST_DONE;
				end
			end
			ST_FETCH: begin
				state_d = ST_MUL_AB;
			end
			ST_MUL_AB: begin
				ctrl.mul_sel = SEL_AB;
				ctrl.mul_en  = 1'b1;
				state_d = ST_MUL_LO;
			end
			ST_MUL_LO: begin
				ctrl.mul_sel = SEL_LO;
				ctrl.mul_en  = 1'b1;
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				ctrl.mul_sel = SEL_HI;
				ctrl.mul_en  = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				ctrl.acc_en = 1'b1;
				state_d = more_q ? ST_MUL_AB : ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// query context and orbital counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			nocc_q    <= '0;
			nend_q    <= '0;
			more_q    <= 1'b0;
			acc_vir_q <= 1'b0;
		end else begin
			if (query_acc) begin
				k_q       <= '0;
				nocc_q    <= nocc;
				nend_q    <= nend;
				acc_vir_q <= (nocc == '0);
			end else if (state_q == ST_MUL_HI) begin
				k_q    <= k_q + COUNT_W'(1);
				more_q <= (k_q + COUNT_W'(1)) < nend_q;
			end else if (state_q == ST_ACC) begin
				acc_vir_q <= in_vir;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			w_q   <= weight_index;
			row_q <= row;
			col_q <= column;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_weight_index_q <= w_q;
			out_row_q          <= row_q;
			out_column_q       <= col_q;
			occ_out_q          <= occ_acc;
			vir_out_q          <= vir_acc;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_weight_index = out_weight_index_q;
	assign out_row          = out_row_q;
	assign out_column       = out_column_q;
	assign occ_density      = occ_out_q;
	assign vir_density      = vir_out_q;

	// checks
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result item raised without a finished query");

	a_orbital_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_AB) |-> (k_q < nend_q))
		else $error("orbital counter ran past the end of the walk");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("query finished over a result item still waiting");

endmodule
